// ===== hdl/imc_pkg.sv =====
// ----------------------------------------------------------------------------
// imc_pkg
// Shared widths, codes and types of the integer mask convolution unit.
// ----------------------------------------------------------------------------
package imc_pkg;

  // tap table geometry
  localparam int MAX_TAPS = 64;
  localparam int ADDR_W   = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // field widths
  localparam int TAP_COUNT_W = 7;
  localparam int SHIFT_W     = 4;
  localparam int COEF_W      = 16;
  localparam int PIXEL_W     = 8;
  localparam int SLOT_W      = 6;
  localparam int ACC_W       = 16;
  localparam int OUT_W       = 8;
  localparam int PROD_W      = PIXEL_W + 1 + COEF_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    CMD_COEF  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT     = 2'd0,
    CFG_PRODUCT_SHIFT = 2'd1,
    CFG_FINAL_SHIFT   = 2'd2,
    CFG_BIAS          = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TAP_COUNT_W-1:0]  tap_count;
    logic [SHIFT_W-1:0]      product_shift;
    logic [SHIFT_W-1:0]      final_shift;
    logic signed [ACC_W-1:0] bias;
  } cfg_t;

  // per-tap control carried along the pipeline
  typedef struct packed {
    logic valid;
    logic odd;
    logic first;
    logic last;
  } tap_ctrl_t;

  // result-producing requests still in the pipeline
  typedef struct packed {
    logic s1_last;
    logic s2_last;
    logic s3_valid;
  } pipe_status_t;

endpackage

// ===== hdl/imc_channels.sv =====
// ----------------------------------------------------------------------------
// imc channels
// Valid/ready channels of the unit: samples in, results out, config writes.
// ----------------------------------------------------------------------------
interface imc_sample_if import imc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cmd_t                     cmd;
  logic [SLOT_W-1:0]        tap_index;
  logic signed [COEF_W-1:0] coefficient;
  logic [PIXEL_W-1:0]       pixel;

  modport source (output valid, cmd, tap_index, coefficient, pixel, input ready);
  modport sink   (input valid, cmd, tap_index, coefficient, pixel, output ready);
endinterface

interface imc_result_if import imc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink   (input valid, out_pixel, output ready);
endinterface

interface imc_cfg_if import imc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/integer_mask_convolution_uchar_unit.sv =====
// Takes one request per cycle while sample.ready is high. A coefficient
// request writes the tap table; a pixel request reads its coefficient from
// the table and passes through a four-stage pipeline (table read, multiply,
// pair accumulate, final scaling); the last pixel of a group pushes its
// result into the queue. The pair accumulator updates without a stall, which
// keeps the rate at one request per cycle. Results wait in an eight-entry
// queue; sample.ready drops only in reset or when that queue plus the results
// still in the pipeline reach eight. The tap table needs no clearing, so
// requests are taken once reset is low. Config writes are taken outside reset.
// ----------------------------------------------------------------------------
// integer_mask_convolution_uchar_unit
// Sparse integer mask convolution producing clamped 8-bit pixels.
// ----------------------------------------------------------------------------
module integer_mask_convolution_uchar_unit import imc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  imc_sample_if.sink   sample,
  imc_result_if.source result,
  imc_cfg_if.sink      cfg
);

  cfg_t                     cfg_regs;
  logic                     sample_acc;
  logic                     tap_req;
  logic                     coef_we;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [COEF_W-1:0] rd_data;
  logic                     push;
  logic [OUT_W-1:0]         push_data;
  pipe_status_t             status;
  logic [FIFO_CNT_W-1:0]    fifo_count;
  logic [FIFO_CNT_W:0]      occupancy;

  // config registers
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.tap_count     <= TAP_COUNT_W'(1);
      cfg_regs.product_shift <= '0;
      cfg_regs.final_shift   <= '0;
      cfg_regs.bias          <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_TAP_COUNT:     cfg_regs.tap_count     <= cfg.data[TAP_COUNT_W-1:0];
        CFG_PRODUCT_SHIFT: cfg_regs.product_shift <= cfg.data[SHIFT_W-1:0];
        CFG_FINAL_SHIFT:   cfg_regs.final_shift   <= cfg.data[SHIFT_W-1:0];
        CFG_BIAS:          cfg_regs.bias          <= cfg.data[ACC_W-1:0];
      endcase
    end
  end

  // request acceptance against queue space
  assign occupancy = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(status.s1_last)
                   + (FIFO_CNT_W+1)'(status.s2_last) + (FIFO_CNT_W+1)'(status.s3_valid);
  assign sample.ready = !rst && (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign sample_acc   = sample.valid && sample.ready;
  assign tap_req      = sample_acc && (sample.cmd == CMD_PIXEL);
  assign coef_we      = sample_acc && (sample.cmd == CMD_COEF)
                      && (int'(sample.tap_index) < MAX_TAPS);

  imc_coef_ram u_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (ADDR_W'(sample.tap_index)),
    .wdata (sample.coefficient),
    .re    (tap_req),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  imc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .tap_req   (tap_req),
    .pixel     (sample.pixel),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .push      (push),
    .push_data (push_data),
    .status    (status)
  );

  imc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .result    (result),
    .count     (fifo_count)
  );

endmodule

// ===== hdl/imc_coef_ram.sv =====
// ----------------------------------------------------------------------------
// imc_coef_ram
// Coefficient tap table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module imc_coef_ram import imc_pkg::*; (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [COEF_W-1:0] wdata,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [COEF_W-1:0] rdata
);

  logic signed [COEF_W-1:0] mem [MAX_TAPS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/imc_datapath.sv =====
// ----------------------------------------------------------------------------
// imc_datapath
// Tap sequencing, multiply, pair accumulate and final scaling/clamp.
// ----------------------------------------------------------------------------
module imc_datapath import imc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     tap_req,
  input  logic [PIXEL_W-1:0]       pixel,
  output logic [ADDR_W-1:0]        rd_addr,
  input  logic signed [COEF_W-1:0] rd_data,
  output logic                     push,
  output logic [OUT_W-1:0]         push_data,
  output pipe_status_t             status
);

  logic [CNT_W-1:0]         tap_counter;
  logic [CNT_W-1:0]         n_eff;
  logic                     last0;

  tap_ctrl_t                s1;
  logic [PIXEL_W-1:0]       s1_pixel;
  logic signed [PROD_W-1:0] product;

  tap_ctrl_t                s2;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [PROD_W-1:0] pend;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W:0]   pair_raw;
  logic signed [PROD_W:0]   pair_shift;
  logic signed [ACC_W-1:0]  pair_sat;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_new;

  logic                     s3_valid;
  logic signed [ACC_W-1:0]  s3_acc;
  logic signed [ACC_W-1:0]  acc_scaled;
  logic [ACC_W-1:0]         biased;

  // effective tap count and last-tap flag
  always_comb begin
    if (cfg.tap_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(cfg.tap_count) > MAX_TAPS) begin
      n_eff = CNT_W'(MAX_TAPS);
    end else begin
      n_eff = CNT_W'(cfg.tap_count);
    end
    last0 = ({1'b0, tap_counter} + (CNT_W+1)'(1)) >= {1'b0, n_eff};
  end

  assign rd_addr = tap_counter[ADDR_W-1:0];

  // stage 0: tap counter, table read issued
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_counter <= '0;
      s1.valid    <= 1'b0;
    end else begin
      s1.valid <= tap_req;
      if (tap_req) begin
        tap_counter <= last0 ? '0 : tap_counter + CNT_W'(1);
      end
    end
    s1.odd   <= tap_counter[0];
    s1.first <= !tap_counter[0] && !last0;
    s1.last  <= last0;
    s1_pixel <= pixel;
  end

  // stage 1: pixel times coefficient
  assign product = $signed({1'b0, s1_pixel}) * rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.odd   <= s1.odd;
    s2.first <= s1.first;
    s2.last  <= s1.last;
    s2_prod  <= product;
  end

  // stage 2: pair sum, shift, saturate, accumulate
  always_comb begin
    pair_raw   = s2.odd ? ((PROD_W+1)'(pend) + (PROD_W+1)'(s2_prod)) : (PROD_W+1)'(s2_prod);
    pair_shift = pair_raw >>> cfg.product_shift;
    if (pair_shift[PROD_W:ACC_W-1] == '0 || pair_shift[PROD_W:ACC_W-1] == '1) begin
      pair_sat = pair_shift[ACC_W-1:0];
    end else begin
      pair_sat = pair_shift[PROD_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    acc_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(pair_sat);
    if (acc_sum[ACC_W] == acc_sum[ACC_W-1]) begin
      acc_new = acc_sum[ACC_W-1:0];
    end else begin
      acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      acc      <= '0;
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2.valid && s2.last;
      if (s2.valid) begin
        if (s2.first) begin
          pend <= s2_prod;
        end else if (s2.last) begin
          pend <= '0;
          acc  <= '0;
        end else begin
          pend <= '0;
          acc  <= acc_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid && s2.last) begin
      s3_acc <= acc_new;
    end
  end

  // stage 3: final shift, bias with wrap, clamp to pixel range
  always_comb begin
    acc_scaled = s3_acc >>> cfg.final_shift;
    biased     = acc_scaled + cfg.bias;
    if (biased[ACC_W-1]) begin
      push_data = '0;
    end else if (biased[ACC_W-2:OUT_W] != '0) begin
      push_data = '1;
    end else begin
      push_data = biased[OUT_W-1:0];
    end
  end

  assign push = s3_valid;

  assign status.s1_last  = s1.valid && s1.last;
  assign status.s2_last  = s2.valid && s2.last;
  assign status.s3_valid = s3_valid;

endmodule

// ===== hdl/imc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// imc_out_fifo
// Result queue between the pipeline and the result channel.
// ----------------------------------------------------------------------------
module imc_out_fifo import imc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [OUT_W-1:0]      push_data,
  imc_result_if.source          result,
  output logic [FIFO_CNT_W-1:0] count
);

  logic [OUT_W-1:0]      mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign result.valid     = count != '0;
  assign result.out_pixel = mem[rd_ptr];
  assign pop              = result.valid && result.ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/imc_checker.sv =====
// ----------------------------------------------------------------------------
// imc_checker
// Port-level checks of the convolution unit, bound to the top level.
// ----------------------------------------------------------------------------
module imc_checker import imc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_ready,
  input logic             sample_cmd,
  input logic             result_valid,
  input logic             result_ready,
  input logic [OUT_W-1:0] result_out_pixel
);

  // a result appears on an empty channel only after an accepted pixel request
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_valid && sample_ready && sample_cmd == CMD_PIXEL, 4))
    else $error("result offered without a matching pixel request");

  // back-pressure on requests only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> result_valid)
    else $error("request stalled with no result waiting");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_out_pixel))
    else $error("stalled result changed or dropped");

endmodule

bind integer_mask_convolution_uchar_unit imc_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .sample_valid     (sample.valid),
  .sample_ready     (sample.ready),
  .sample_cmd       (sample.cmd),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_out_pixel (result.out_pixel)
);

// ===== tb/integer_mask_convolution_uchar_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_mask_convolution_uchar_unit_tb
// Drives coefficient and pixel requests into the convolution unit, predicts
// each clamped output pixel in a behavioural model kept alongside, and checks
// every result in order. A directed table runs first, then random requests
// under several register settings and three handshake idling profiles.
// ----------------------------------------------------------------------------
module integer_mask_convolution_uchar_unit_tb;
  import imc_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_TAIL  = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int BLOCK_REQS  = 95;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 37;

  typedef enum {ROW_CFG, ROW_COEF, ROW_PIXEL} row_kind_t;

  // addr: register index or table slot; value: data, coefficient or pixel
  // (a negative pixel means random); want: typed result, negative if none
  typedef struct {
    row_kind_t kind;
    int        addr;
    int        value;
    int        reps;
    int        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  imc_sample_if sample_ch();
  imc_result_if result_ch();
  imc_cfg_if    cfg_ch();

  integer_mask_convolution_uchar_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // shadow of the unit: registers, tap table and running pixel state
  logic [TAP_COUNT_W-1:0]   taps_reg;
  logic [SHIFT_W-1:0]       prod_shift_reg;
  logic [SHIFT_W-1:0]       final_shift_reg;
  logic signed [ACC_W-1:0]  bias_reg;
  logic signed [COEF_W-1:0] tap_table [MAX_TAPS];
  int                       acc_sum;
  int                       taps_seen;
  int                       held_product;

  logic [OUT_W-1:0] awaited_pixels [$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               burst_req;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_COEF,  0, 32767, 1, -1},
    '{ROW_PIXEL, 0, 255, 1, 255},          // product saturates high
    '{ROW_PIXEL, 0, 0, 1, 0},
    '{ROW_COEF,  0, -32768, 1, -1},
    '{ROW_PIXEL, 0, 255, 1, 0},            // saturates low, clamps to zero
    '{ROW_COEF,  0, 1, 1, -1},
    '{ROW_PIXEL, 0, 200, 1, 200},
    '{ROW_COEF,  MAX_TAPS - 1, 3, 1, -1},
    '{ROW_CFG,   CFG_TAP_COUNT, 0, 1, -1}, // zero taps behave as one
    '{ROW_PIXEL, 0, 77, 1, 77},
    '{ROW_CFG,   CFG_BIAS, 32767, 1, -1},
    '{ROW_PIXEL, 0, 0, 1, 255},
    '{ROW_COEF,  0, 32767, 1, -1},
    '{ROW_PIXEL, 0, 255, 1, 0},            // bias add wraps negative
    '{ROW_CFG,   CFG_BIAS, -32768, 1, -1},
    '{ROW_PIXEL, 0, 255, 1, 0},
    '{ROW_CFG,   CFG_BIAS, 0, 1, -1},
    '{ROW_CFG,   CFG_PRODUCT_SHIFT, 15, 1, -1},
    '{ROW_PIXEL, 0, 255, 1, 254},
    '{ROW_CFG,   CFG_FINAL_SHIFT, 15, 1, -1},
    '{ROW_PIXEL, 0, 255, 1, 0},
    '{ROW_CFG,   CFG_PRODUCT_SHIFT, 0, 1, -1},
    '{ROW_CFG,   CFG_FINAL_SHIFT, 4, 1, -1},
    '{ROW_CFG,   CFG_TAP_COUNT, 127, 1, -1}, // clipped to the table size
    '{ROW_PIXEL, 0, -1, MAX_TAPS, -1},
    '{ROW_CFG,   CFG_TAP_COUNT, 3, 1, -1},
    '{ROW_PIXEL, 0, -1, 1, -1},
    '{ROW_COEF,  1, -5, 1, -1},            // table write inside a pixel
    '{ROW_PIXEL, 0, -1, 2, -1},            // odd last tap on its own
    '{ROW_CFG,   CFG_TAP_COUNT, 4, 1, -1},
    '{ROW_PIXEL, 0, -1, 1, -1},
    '{ROW_CFG,   CFG_TAP_COUNT, 1, 1, -1}, // lowered with a tap pending
    '{ROW_PIXEL, 0, -1, 1, -1},
    '{ROW_CFG,   CFG_TAP_COUNT, 4, 1, -1},
    '{ROW_PIXEL, 0, -1, 2, -1},
    '{ROW_CFG,   CFG_TAP_COUNT, 2, 1, -1}, // lowered on a pair boundary
    '{ROW_PIXEL, 0, -1, 1, -1}
  };

  function automatic int clip16(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // one request into the shadow; returns 1 when it completes an output pixel
  function automatic bit convolve_request(cmd_t cmd, logic [SLOT_W-1:0] slot,
                                          logic signed [COEF_W-1:0] coef,
                                          logic [PIXEL_W-1:0] pix,
                                          output logic [OUT_W-1:0] px);
    int n, pv, cv, prod, pair, v, b;
    bit last;
    logic [ACC_W-1:0] wrapped;
    px = '0;
    if (cmd == CMD_COEF) begin
      tap_table[slot] = coef;
      return 1'b0;
    end
    n = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
    last = (taps_seen + 1 >= n);
    pv = pix;
    cv = tap_table[taps_seen % MAX_TAPS];
    prod = pv * cv;
    // first tap of a pair waits for its partner
    if (taps_seen % 2 == 0 && !last) begin
      held_product = prod;
      taps_seen++;
      return 1'b0;
    end
    pair = (taps_seen % 2 != 0) ? held_product + prod : prod;
    pair = clip16(pair >>> prod_shift_reg);
    acc_sum = clip16(acc_sum + pair);
    held_product = 0;
    if (!last) begin
      taps_seen++;
      return 1'b0;
    end
    // final scaling, wrapping bias add, clamp to a byte
    v = acc_sum >>> final_shift_reg;
    b = bias_reg;
    wrapped = ACC_W'(v + b);
    v = $signed(wrapped);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    px = v[OUT_W-1:0];
    acc_sum = 0;
    taps_seen = 0;
    held_product = 0;
    return 1'b1;
  endfunction

  // offer one request, predict once it is taken; entered and left at negedge
  task automatic push_request(cmd_t cmd, logic [SLOT_W-1:0] slot,
                              logic signed [COEF_W-1:0] coef,
                              logic [PIXEL_W-1:0] pix, int want);
    logic [OUT_W-1:0] px;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.cmd         <= cmd;
    sample_ch.tap_index   <= slot;
    sample_ch.coefficient <= coef;
    sample_ch.pixel       <= pix;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    if (convolve_request(cmd, slot, coef, pix, px))
      awaited_pixels.push_back((want < 0) ? px : OUT_W'(want));
  endtask

  // stop offering and wait until every awaited pixel is out
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_TAP_COUNT:     taps_reg = value[TAP_COUNT_W-1:0];
      CFG_PRODUCT_SHIFT: prod_shift_reg = value[SHIFT_W-1:0];
      CFG_FINAL_SHIFT:   final_shift_reg = value[SHIFT_W-1:0];
      CFG_BIAS:          bias_reg = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // result sink: random stalls plus a long hold when asked
  initial begin
    int hold_left;
    int bursts_seen;
    hold_left = 0;
    bursts_seen = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (burst_req != bursts_seen) begin
        bursts_seen = burst_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_pixels.size() == 0) begin
        $error("out_pixel: expected none, got %0d", result_ch.out_pixel);
        error_count++;
      end else begin
        want = awaited_pixels.pop_front();
        if (result_ch.out_pixel !== want) begin
          $error("out_pixel: expected %0d, got %0d", want, result_ch.out_pixel);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL integer_mask_convolution_uchar_unit");
      $finish;
    end
  end

  // stimulus
  initial begin
    int r, k, ph, blk, pix, cv;
    logic [CFG_DATA_W-1:0] v;
    rst = 1'b1;
    sample_ch.valid       = 1'b0;
    sample_ch.cmd         = CMD_COEF;
    sample_ch.tap_index   = '0;
    sample_ch.coefficient = '0;
    sample_ch.pixel       = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_TAP_COUNT;
    cfg_ch.data           = '0;
    send_idle_pct  = 24;
    recv_stall_pct = 78;
    burst_req      = 0;
    taps_reg        = 1;
    prod_shift_reg  = '0;
    final_shift_reg = '0;
    bias_reg        = '0;
    acc_sum      = 0;
    taps_seen    = 0;
    held_product = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // load every slot so no tap ever reads an unwritten coefficient
    for (k = 0; k < MAX_TAPS; k++)
      push_request(CMD_COEF, SLOT_W'(k), COEF_W'($urandom), PIXEL_W'($urandom), -1);

    // directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      case (dir_rows[r].kind)
        ROW_CFG: begin
          settle();
          write_register(cfg_idx_t'(dir_rows[r].addr), CFG_DATA_W'(dir_rows[r].value));
        end
        ROW_COEF: begin
          push_request(CMD_COEF, SLOT_W'(dir_rows[r].addr), COEF_W'(dir_rows[r].value),
                       PIXEL_W'($urandom), -1);
        end
        default: begin
          for (k = 0; k < dir_rows[r].reps; k++) begin
            pix = (dir_rows[r].value < 0) ? $urandom_range(0, 255) : dir_rows[r].value;
            push_request(CMD_PIXEL, SLOT_W'($urandom), COEF_W'($urandom), PIXEL_W'(pix),
                         dir_rows[r].want);
          end
        end
      endcase
    end

    // random requests: three idling profiles, several settings in each
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 24 : (ph == 1) ? 78 : 0;
      recv_stall_pct <= (ph == 0) ? 78 : (ph == 1) ? 24 : 0;
      for (blk = 0; blk < 4; blk++) begin
        settle();
        // long result hold while requests keep coming, one pixel per request
        if (ph == 2 && blk == 0) begin
          write_register(CFG_TAP_COUNT, CFG_DATA_W'(1));
          burst_req <= burst_req + 1;
          for (k = 0; k < 40; k++)
            push_request(CMD_PIXEL, SLOT_W'($urandom), COEF_W'($urandom),
                         PIXEL_W'($urandom), -1);
          settle();
        end
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = 127;
          2: v = CFG_DATA_W'(MAX_TAPS);
          3: v = CFG_DATA_W'($urandom_range(9, MAX_TAPS - 1));
          default: v = CFG_DATA_W'($urandom_range(1, 8));
        endcase
        write_register(CFG_TAP_COUNT, v);
        v = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'(15 * $urandom_range(0, 1))
                                        : CFG_DATA_W'($urandom_range(0, 15));
        write_register(CFG_PRODUCT_SHIFT, v);
        v = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'(15 * $urandom_range(0, 1))
                                        : CFG_DATA_W'($urandom_range(0, 15));
        write_register(CFG_FINAL_SHIFT, v);
        case ($urandom_range(0, 7))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2, 3: v = CFG_DATA_W'($urandom);
          default: v = CFG_DATA_W'(int'($urandom_range(0, 300)) - 40);
        endcase
        write_register(CFG_BIAS, v);
        for (k = 0; k < BLOCK_REQS; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            cv = $urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 512) - 256;
            push_request(CMD_COEF, SLOT_W'($urandom_range(0, MAX_TAPS - 1)), COEF_W'(cv),
                         PIXEL_W'($urandom), -1);
          end else begin
            case ($urandom_range(0, 7))
              0: pix = 0;
              1: pix = 255;
              default: pix = $urandom_range(0, 255);
            endcase
            push_request(CMD_PIXEL, SLOT_W'($urandom), COEF_W'($urandom), PIXEL_W'(pix), -1);
          end
        end
      end
    end

    settle();
    if (error_count == 0)
      $display("PASS integer_mask_convolution_uchar_unit");
    else
      $display("FAIL integer_mask_convolution_uchar_unit");
    $finish;
  end

endmodule
